>>> rtl/splat_attribute_decoder_macros.svh
// Assertion macros for the splat attribute decoder.
// Included by the files that check their own logic; no other dependencies.
`ifndef SPLAT_ATTRIBUTE_DECODER_MACROS_SVH
`define SPLAT_ATTRIBUTE_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define SAD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SAD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SAD_ASSERT(lbl, clk, rst_n, prop, msg)
`define SAD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/sad_pkg.sv
// Shared types, constants and decode tables of the splat attribute decoder.
// No dependencies; used by every other file except the assertion macros header.
package sad_pkg;

    localparam int QueueDepth = 2;
    localparam int SqrtSteps  = 16;
    localparam int PosW       = 48;
    localparam int SizeW      = 31;
    localparam int QuatW      = 16;
    localparam int CompW      = 15;
    localparam int CfgIdxW    = 4;
    localparam int CfgDataW   = 8;

    localparam logic [CfgIdxW-1:0] CfgVersion  = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CfgFracBits = CfgIdxW'(1);

    localparam logic [1:0] VerXyz      = 2'd2;
    localparam logic [1:0] VerReset    = 2'd3;
    localparam logic [4:0] FracReset   = 5'd12;
    localparam logic [4:0] FracUnity   = 5'd24;

    localparam logic [15:0] HalfSqrtQ16 = 16'd46341;
    localparam logic [24:0] MagRound    = 25'd511;
    localparam longint unsigned RecipQ40Full = ((64'd1 << 40) + 64'd1021) / 64'd1022;
    localparam logic [30:0] RecipQ40    = RecipQ40Full[30:0];
    localparam logic [31:0] OneQ30      = 32'h4000_0000;
    localparam logic [14:0] QuatMax     = 15'h7FFF;

    typedef logic [7:0]        t_colour_lut [256];
    typedef logic [CompW-1:0]  t_axis_lut   [256];
    typedef logic [SizeW-1:0]  t_size_lut   [256];

    typedef struct packed {
        logic [2:0][PosW-1:0]  pos;
        logic [31:0]           rgba;
        logic [2:0][SizeW-1:0] size;
        logic                  is_xyz;
        logic [1:0]            derived;
        logic [2:0][1:0]       slot;
        logic [2:0][CompW-1:0] raw;
        logic [2:0]            neg;
    } t_task;

    function automatic t_colour_lut build_colour_lut();
        t_colour_lut lut;
        longint t;
        longint b;
        for (int c = 0; c < 256; c++) begin
            t = 64'sd16711680 + (2 * longint'(c) - 255) * 123249;
            if (t <= 0) begin
                lut[c] = 8'd0;
            end else begin
                b = t / 131072;
                lut[c] = (b > 255) ? 8'd255 : 8'(b);
            end
        end
        return lut;
    endfunction

    function automatic t_axis_lut build_axis_lut();
        t_axis_lut lut;
        longint m;
        longint q;
        for (int b = 0; b < 256; b++) begin
            m = 2 * longint'(b) - 255;
            if (m < 0) m = -m;
            q = (m * 32768 + 127) / 255;
            lut[b] = (q > 32767) ? 15'h7FFF : 15'(q);
        end
        return lut;
    endfunction

    function automatic t_size_lut build_size_lut();
        t_size_lut lut;
        longint unsigned acc;
        longint unsigned p1;
        longint unsigned p2;
        acc = 64'd49917751;
        for (int n = 0; n < 256; n++) begin
            lut[n] = SizeW'((acc + (64'd1 << 17)) >> 18);
            p1 = (acc >> 24) * 64'd4571968888;
            p2 = (acc & 64'hFF_FFFF) * 64'd4571968888;
            acc = (p1 >> 8) + ((((p1 & 64'hFF) << 24) + p2) >> 32);
        end
        return lut;
    endfunction

    localparam t_colour_lut ColourLut = build_colour_lut();
    localparam t_axis_lut   AxisLut   = build_axis_lut();
    localparam t_size_lut   SizeLut   = build_size_lut();

endpackage

>>> rtl/sad_if.sv
// Channel interfaces: splat record in, decoded attributes out, register writes.
// Depends on sad_pkg for widths.
interface sad_rec_if;
    logic        valid;
    logic        ready;
    logic [23:0] coord_x;
    logic [23:0] coord_y;
    logic [23:0] coord_z;
    logic [7:0]  alpha_code;
    logic [7:0]  red_code;
    logic [7:0]  green_code;
    logic [7:0]  blue_code;
    logic [7:0]  scale_code_x;
    logic [7:0]  scale_code_y;
    logic [7:0]  scale_code_z;
    logic [31:0] rotation_word;
    modport source (output valid, coord_x, coord_y, coord_z, alpha_code, red_code,
                    green_code, blue_code, scale_code_x, scale_code_y, scale_code_z,
                    rotation_word, input ready);
    modport sink   (input valid, coord_x, coord_y, coord_z, alpha_code, red_code,
                    green_code, blue_code, scale_code_x, scale_code_y, scale_code_z,
                    rotation_word, output ready);
endinterface

interface sad_dec_if;
    logic                               valid;
    logic                               ready;
    logic signed [sad_pkg::PosW-1:0]    pos_x;
    logic signed [sad_pkg::PosW-1:0]    pos_y;
    logic signed [sad_pkg::PosW-1:0]    pos_z;
    logic [31:0]                        rgba;
    logic [sad_pkg::SizeW-1:0]          size_x;
    logic [sad_pkg::SizeW-1:0]          size_y;
    logic [sad_pkg::SizeW-1:0]          size_z;
    logic signed [sad_pkg::QuatW-1:0]   quat_0;
    logic signed [sad_pkg::QuatW-1:0]   quat_1;
    logic signed [sad_pkg::QuatW-1:0]   quat_2;
    logic signed [sad_pkg::QuatW-1:0]   quat_3;
    modport source (output valid, pos_x, pos_y, pos_z, rgba, size_x, size_y, size_z,
                    quat_0, quat_1, quat_2, quat_3, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, rgba, size_x, size_y, size_z,
                    quat_0, quat_1, quat_2, quat_3, output ready);
endinterface

interface sad_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sad_pkg::CfgIdxW-1:0]    index;
    logic [sad_pkg::CfgDataW-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/sad_front.sv
// Front end: holds the registers, accepts records and turns them into decode tasks.
// Depends on sad_pkg tables and the channel interfaces.
module sad_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sad_rec_if.sink          i_rec,
    sad_cfg_if.sink          i_cfg,
    input  logic             i_q_full,
    output logic             o_push,
    output sad_pkg::t_task   o_task
);
    localparam int PosWm1 = sad_pkg::PosW - 1;

    logic [1:0]      r_version;
    logic [4:0]      r_frac_bits;
    logic            r_vld;
    sad_pkg::t_task  r_task;
    sad_pkg::t_task  n_task;
    logic [2:0][23:0] coord;
    logic [2:0][7:0]  colour;
    logic [2:0][7:0]  scale;
    logic [2:0][7:0]  axis_b;
    logic [2:0][9:0]  chunk;
    logic [PosWm1:0]  sext;
    logic [1:0]       largest;
    logic [2:0]       base;
    logic             accept;

    assign i_cfg.ready = 1'b1;
    assign i_rec.ready = !r_vld || !i_q_full;
    assign accept      = i_rec.valid && i_rec.ready;
    assign o_push      = r_vld && !i_q_full;
    assign o_task      = r_task;

    assign coord   = {i_rec.coord_z, i_rec.coord_y, i_rec.coord_x};
    assign colour  = {i_rec.blue_code, i_rec.green_code, i_rec.red_code};
    assign scale   = {i_rec.scale_code_z, i_rec.scale_code_y, i_rec.scale_code_x};
    assign axis_b  = i_rec.rotation_word[23:0];
    assign chunk   = i_rec.rotation_word[29:0];
    assign largest = i_rec.rotation_word[31:30];

    always_comb begin
        n_task        = '0;
        sext          = '0;
        base          = '0;
        n_task.is_xyz = (r_version == sad_pkg::VerXyz);
        n_task.rgba[31:24] = i_rec.alpha_code;
        for (int k = 0; k < 3; k++) begin
            sext = {{(sad_pkg::PosW - 24){coord[k][23]}}, coord[k]};
            if (r_frac_bits <= sad_pkg::FracUnity) begin
                n_task.pos[k] = sext << (sad_pkg::FracUnity - r_frac_bits);
            end else begin
                n_task.pos[k] = $signed(sext) >>> (r_frac_bits - sad_pkg::FracUnity);
            end
            n_task.rgba[8*k +: 8] = sad_pkg::ColourLut[colour[k]];
            n_task.size[k]        = sad_pkg::SizeLut[scale[k]];
            if (n_task.is_xyz) begin
                n_task.slot[k] = 2'(k + 1);
                n_task.raw[k]  = sad_pkg::AxisLut[axis_b[k]];
                n_task.neg[k]  = !axis_b[k][7];
            end else begin
                // walk slots from three down, stepping over the largest one
                base = 3'(3 - k);
                n_task.slot[k] = (base > {1'b0, largest}) ? base[1:0] : 2'(2 - k);
                n_task.raw[k]  = {6'd0, chunk[k][8:0]};
                n_task.neg[k]  = chunk[k][9];
            end
        end
        n_task.derived = n_task.is_xyz ? 2'd0 : largest;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version   <= sad_pkg::VerReset;
            r_frac_bits <= sad_pkg::FracReset;
            r_vld       <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == sad_pkg::CfgVersion) begin
                    r_version <= i_cfg.data[1:0];
                end else if (i_cfg.index == sad_pkg::CfgFracBits) begin
                    r_frac_bits <= i_cfg.data[4:0];
                end
            end
            if (accept) begin
                r_vld <= 1'b1;
            end else if (o_push) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_task <= n_task;
        end
    end
endmodule

>>> rtl/sad_fifo.sv
// Short task queue between the front end and the decode pipeline.
// Depends on sad_pkg for the task type and on the assertion macros.
`include "splat_attribute_decoder_macros.svh"
module sad_fifo #(
    parameter int DEPTH = sad_pkg::QueueDepth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sad_pkg::t_task  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output sad_pkg::t_task  o_data
);
    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    sad_pkg::t_task   r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr;
    logic [PtrW-1:0]  r_rd;
    logic [CntW-1:0]  r_count;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `SAD_ASSERT(a_no_push_full, i_clk, i_rst_n, i_push |-> !o_full, "push into full queue")
    `SAD_ASSERT(a_no_pop_empty, i_clk, i_rst_n, i_pop |-> o_valid, "pop from empty queue")
    `SAD_ASSERT(a_count_up, i_clk, i_rst_n, (i_push && !i_pop) |=> (r_count == $past(r_count) + CntW'(1)), "queue count lost a push")
endmodule

>>> rtl/sad_back.sv
// Decode pipeline: non-xyz component scaling, squares, radicand, a staged square root, quaternion assembly.
// Depends on sad_pkg and the result interface.
module sad_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  sad_pkg::t_task  i_task,
    output logic            o_pop,
    sad_dec_if.source       o_dec
);
    localparam int NStg = 4 + sad_pkg::SqrtSteps;

    typedef struct packed {
        sad_pkg::t_task   tsk;
        logic [2:0][24:0] cv;
        logic [2:0][29:0] sq;
        logic [30:0]      rem;
        logic [30:0]      root;
    } t_stage;

    t_stage            r_st [NStg];
    t_stage            n_st [NStg];
    logic [NStg-1:0]   r_vld;
    logic              r_out_vld;
    logic              en;
    logic [55:0]       prod [3];
    logic [31:0]       sum;
    logic [31:0]       trial;
    logic [31:0]       bitv;
    logic [3:0][15:0]  quat;
    logic [15:0]       mag;
    t_stage            last;

    sad_pkg::t_task      r_task;
    logic [3:0][15:0]    r_quat;

    assign en    = !r_out_vld || o_dec.ready;
    assign o_pop = en && i_valid;
    assign last  = r_st[NStg-1];

    always_comb begin
        for (int s = 0; s < NStg; s++) n_st[s] = '0;
        sum   = '0;
        trial = '0;
        bitv  = '0;
        for (int k = 0; k < 3; k++) prod[k] = '0;

        // magnitude times sqrt(1/2), with rounding offset
        n_st[0].tsk = i_task;
        for (int k = 0; k < 3; k++) begin
            n_st[0].cv[k] = i_task.is_xyz ? {10'd0, i_task.raw[k]} :
                            25'(i_task.raw[k][8:0] * sad_pkg::HalfSqrtQ16) + sad_pkg::MagRound;
        end

        // divide by 1022 through a reciprocal
        n_st[1] = r_st[0];
        for (int k = 0; k < 3; k++) begin
            prod[k] = r_st[0].cv[k] * sad_pkg::RecipQ40;
            if (!r_st[0].tsk.is_xyz) n_st[1].cv[k] = {10'd0, prod[k][54:40]};
        end

        n_st[2] = r_st[1];
        for (int k = 0; k < 3; k++) begin
            n_st[2].sq[k] = r_st[1].cv[k][14:0] * r_st[1].cv[k][14:0];
        end

        // radicand, clamped at zero
        n_st[3] = r_st[2];
        sum = 32'(r_st[2].sq[0]) + 32'(r_st[2].sq[1]) + 32'(r_st[2].sq[2]);
        n_st[3].rem  = (sum >= sad_pkg::OneQ30) ? '0 : 31'(sad_pkg::OneQ30 - sum);
        n_st[3].root = '0;

        for (int s = 4; s < NStg; s++) begin
            n_st[s] = r_st[s-1];
            bitv  = 32'(sad_pkg::OneQ30) >> (2 * (s - 4));
            trial = 32'(r_st[s-1].root) + bitv;
            if (32'(r_st[s-1].rem) >= trial) begin
                n_st[s].rem  = 31'(32'(r_st[s-1].rem) - trial);
                n_st[s].root = 31'((32'(r_st[s-1].root) >> 1) + bitv);
            end else begin
                n_st[s].root = r_st[s-1].root >> 1;
            end
        end
    end

    always_comb begin
        quat = '0;
        mag  = '0;
        for (int k = 0; k < 3; k++) begin
            mag = {1'b0, last.cv[k][14:0]};
            quat[last.tsk.slot[k]] = last.tsk.neg[k] ? (16'd0 - mag) : mag;
        end
        quat[last.tsk.derived] = (last.root > 31'(sad_pkg::QuatMax)) ?
                                 {1'b0, sad_pkg::QuatMax} : {1'b0, last.root[14:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[NStg-2:0], i_valid};
            r_out_vld <= r_vld[NStg-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < NStg; s++) r_st[s] <= n_st[s];
            r_task <= last.tsk;
            r_quat <= quat;
        end
    end

    assign o_dec.valid  = r_out_vld;
    assign o_dec.pos_x  = r_task.pos[0];
    assign o_dec.pos_y  = r_task.pos[1];
    assign o_dec.pos_z  = r_task.pos[2];
    assign o_dec.rgba   = r_task.rgba;
    assign o_dec.size_x = r_task.size[0];
    assign o_dec.size_y = r_task.size[1];
    assign o_dec.size_z = r_task.size[2];
    assign o_dec.quat_0 = r_quat[0];
    assign o_dec.quat_1 = r_quat[1];
    assign o_dec.quat_2 = r_quat[2];
    assign o_dec.quat_3 = r_quat[3];
endmodule

>>> rtl/splat_attribute_decoder.sv
// Splat attribute decoder top level. Path from accept to result valid: front register, queue,
// 20 decode stages feeding the result register.
// Throughput: one record per cycle unless stalled; the square root is one pipeline stage per
// result bit, 16 stages. Any output stall holds the pipeline; the queue absorbs it.
// Reset (synchronous, active low) empties all stages and sets version 3, 12 fraction bits.
module splat_attribute_decoder #(
    parameter int QUEUE_DEPTH = sad_pkg::QueueDepth
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    sad_rec_if.sink i_rec,
    sad_cfg_if.sink i_cfg,
    sad_dec_if.source o_dec
);
    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_valid;
    sad_pkg::t_task  f_task;
    sad_pkg::t_task  q_task;

    sad_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rec    (i_rec),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_task   (f_task)
    );

    sad_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_task),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_task)
    );

    sad_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_task  (q_task),
        .o_pop   (q_pop),
        .o_dec   (o_dec)
    );
endmodule
